/* rtl/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// tpd_pkg
// shared types and codes of the texture pixel decoder
// ----------------------------------------------------------------------------
package tpd_pkg;

  // default palette depth, handed to the top level parameter
  localparam int PALETTE_DEPTH_DEF = 256;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PIXELS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 2'd3;

  // input beat opcodes
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_DATA    = 1'b1;

  typedef enum logic [1:0] {
    MODE_PAL4     = 2'd0,
    MODE_PAL8     = 2'd1,
    MODE_DIRECT15 = 2'd2,
    MODE_DIRECT24 = 2'd3
  } pix_mode_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  palette_index;
    logic [15:0] palette_value;
    logic [7:0]  data_byte;
  } tpd_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       bad_index;
    logic       last_of_run;
    logic       end_of_image;
  } tpd_out_t;

endpackage

/* rtl/tim_pixel_decoder_unit.sv */
// ----------------------------------------------------------------------------
// tim_pixel_decoder_unit: texture pixel stream decoder with palette memory
// a data byte's pixel passes the read stage and the result queue to out_valid
// throughput: 1 beat per cycle while the queue has room and no clut4 high
// nibble holds the single palette read port; direct modes use 2 or 3 bytes
// reset: registers take their defaults, palette memory is not cleared
// ----------------------------------------------------------------------------
module tim_pixel_decoder_unit
  import tpd_pkg::*;
#(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tpd_in_t               in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output tpd_out_t              out_data,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // palette address width and bound for the index check
  localparam int         AW      = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_L = 9'(PALETTE_DEPTH);

  // result queue behind the memory read stage
  localparam int QDEPTH = 3;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // where a pixel's colour comes from in the read stage
  typedef enum logic [1:0] {
    SRC_PAL  = 2'd0,
    SRC_WORD = 2'd1,
    SRC_RGB  = 2'd2
  } src_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // width and height are kept as their effective value (zero reads as one),
  // the pixel total minus one and the 24-bit line length are set up here so
  // the decode path only compares
  // --------------------------------------------------------------------------
  pix_mode_t   mode_r;
  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [8:0]  pal_count_r;
  logic [31:0] total_m1_r;
  logic [17:0] line_len_r;

  logic [15:0] cfg_eff;
  logic [15:0] cfg_mul_a;
  logic [15:0] cfg_mul_b;
  logic [31:0] cfg_prod;
  logic        cfg_restart;

  assign cfg_eff     = (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
  assign cfg_mul_a   = (cfg_index == CFG_WIDTH_PIXELS) ? cfg_eff : width_r;
  assign cfg_mul_b   = (cfg_index == CFG_HEIGHT_ROWS) ? cfg_eff : height_r;
  assign cfg_prod    = 32'(cfg_mul_a) * 32'(cfg_mul_b);
  // any write other than the palette count restarts the image
  assign cfg_restart = cfg_we && (cfg_index != CFG_PALETTE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DIRECT15;
      width_r     <= 16'd1;
      height_r    <= 16'd1;
      pal_count_r <= '0;
      total_m1_r  <= '0;
      line_len_r  <= 18'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_MODE: begin
          mode_r <= pix_mode_t'(cfg_wdata[1:0]);
        end
        CFG_WIDTH_PIXELS: begin
          width_r    <= cfg_eff;
          total_m1_r <= cfg_prod - 32'd1;
          // three bytes a pixel, one pad byte on odd widths
          line_len_r <= 18'({cfg_eff, 1'b0}) + 18'(cfg_eff) + 18'(cfg_eff[0]);
        end
        CFG_HEIGHT_ROWS: begin
          height_r   <= cfg_eff;
          total_m1_r <= cfg_prod - 32'd1;
        end
        CFG_PALETTE_COUNT: begin
          pal_count_r <= cfg_wdata[8:0];
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake and credit
  // a pixel is issued only when the result queue has room for it and for
  // the one already in the read stage, so the read data never has to stall
  // --------------------------------------------------------------------------
  logic           nib_pend_r;
  logic [3:0]     nib_idx_r;
  logic           s1_valid_r;
  logic [QCW-1:0] q_cnt_r;
  logic           credit_ok;
  logic           in_fire;

  assign credit_ok = (3'(q_cnt_r) + 3'(s1_valid_r)) < 3'(QDEPTH);
  // the high nibble of a clut4 byte takes the read port while nib_pend_r is set
  assign in_ready  = !nib_pend_r && credit_ok;
  assign in_fire   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // decode state
  // --------------------------------------------------------------------------
  logic [7:0]  held1_r, held1_nxt;
  logic [7:0]  held2_r, held2_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [17:0] lbl_r, lbl_nxt;
  logic [31:0] pd_r, pd_nxt;
  logic        nib_pend_nxt;
  logic [3:0]  nib_idx_nxt;

  // issue into the read stage
  logic        iss_valid;
  src_t        iss_src;
  logic [23:0] iss_raw;
  logic [7:0]  iss_idx;
  logic        iss_last;
  logic        iss_end;
  logic        iss_bad;

  logic        cnt_end;
  logic [31:0] pd_cnt;
  logic        skip24;
  logic [17:0] lbl_tmp;

  // one pixel counted: wraps to zero on the last pixel of the image
  assign cnt_end = (pd_r >= total_m1_r);
  assign pd_cnt  = cnt_end ? '0 : 32'(pd_r + 32'd1);

  always_comb begin
    iss_valid    = 1'b0;
    iss_src      = SRC_PAL;
    iss_raw      = '0;
    iss_idx      = '0;
    iss_last     = 1'b0;
    iss_end      = 1'b0;
    held1_nxt    = held1_r;
    held2_nxt    = held2_r;
    phase_nxt    = phase_r;
    lbl_nxt      = lbl_r;
    pd_nxt       = pd_r;
    nib_pend_nxt = nib_pend_r;
    nib_idx_nxt  = nib_idx_r;
    skip24       = 1'b0;
    lbl_tmp      = lbl_r;

    if (nib_pend_r) begin
      // second pixel of a clut4 byte
      if (credit_ok) begin
        iss_valid    = 1'b1;
        iss_idx      = {4'h0, nib_idx_r};
        iss_last     = 1'b1;
        iss_end      = cnt_end;
        pd_nxt       = pd_cnt;
        nib_pend_nxt = 1'b0;
        if (cnt_end) begin
          phase_nxt = '0;
        end
      end
    end else if (in_fire && (in_data.op == OP_DATA)) begin
      case (mode_r)
        MODE_PAL4: begin
          // low nibble first; an image ending here drops the high nibble
          iss_valid = 1'b1;
          iss_idx   = {4'h0, in_data.data_byte[3:0]};
          iss_last  = cnt_end;
          iss_end   = cnt_end;
          pd_nxt    = pd_cnt;
          if (cnt_end) begin
            phase_nxt = '0;
          end else begin
            nib_pend_nxt = 1'b1;
            nib_idx_nxt  = in_data.data_byte[7:4];
          end
        end
        MODE_PAL8: begin
          iss_valid = 1'b1;
          iss_idx   = in_data.data_byte;
          iss_last  = 1'b1;
          iss_end   = cnt_end;
          pd_nxt    = pd_cnt;
          if (cnt_end) begin
            phase_nxt = '0;
          end
        end
        MODE_DIRECT15: begin
          // little-endian byte pair
          if (phase_r == '0) begin
            held1_nxt = in_data.data_byte;
            phase_nxt = 2'd1;
          end else begin
            iss_valid = 1'b1;
            iss_src   = SRC_WORD;
            iss_raw   = {8'h00, in_data.data_byte, held1_r};
            iss_last  = 1'b1;
            iss_end   = cnt_end;
            pd_nxt    = pd_cnt;
            phase_nxt = '0;
          end
        end
        MODE_DIRECT24: begin
          // line byte counter: loads at line start, pad byte skipped at the end
          if (phase_r == '0) begin
            if (lbl_r == '0) begin
              lbl_tmp = line_len_r;
            end else if (lbl_r < 18'd3) begin
              lbl_tmp = 18'(lbl_r - 18'd1);
              skip24  = 1'b1;
            end
          end
          if (!skip24) begin
            if (lbl_tmp != '0) begin
              lbl_tmp = 18'(lbl_tmp - 18'd1);
            end
            if (phase_r == '0) begin
              held1_nxt = in_data.data_byte;
              phase_nxt = 2'd1;
            end else if (phase_r == 2'd1) begin
              held2_nxt = in_data.data_byte;
              phase_nxt = 2'd2;
            end else begin
              iss_valid = 1'b1;
              iss_src   = SRC_RGB;
              iss_raw   = {held1_r, held2_r, in_data.data_byte};
              iss_last  = 1'b1;
              iss_end   = cnt_end;
              pd_nxt    = pd_cnt;
              phase_nxt = '0;
            end
          end
          lbl_nxt = lbl_tmp;
        end
        default: begin
        end
      endcase
    end

    if (cfg_restart) begin
      phase_nxt = '0;
      lbl_nxt   = '0;
      pd_nxt    = '0;
    end
  end

  // index at or past the loaded count, or past the memory, reads as an error
  assign iss_bad = (iss_src == SRC_PAL) &&
                   (({1'b0, iss_idx} >= pal_count_r) || ({1'b0, iss_idx} >= DEPTH_L));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held1_r    <= '0;
      held2_r    <= '0;
      phase_r    <= '0;
      lbl_r      <= '0;
      pd_r       <= '0;
      nib_pend_r <= 1'b0;
      nib_idx_r  <= '0;
    end else begin
      held1_r    <= held1_nxt;
      held2_r    <= held2_nxt;
      phase_r    <= phase_nxt;
      lbl_r      <= lbl_nxt;
      pd_r       <= pd_nxt;
      nib_pend_r <= nib_pend_nxt;
      nib_idx_r  <= nib_idx_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // palette memory: one write and one registered read per cycle
  // writes come from input beats and reads from issued pixels, a read never
  // meets a write to the same entry in the same cycle
  // --------------------------------------------------------------------------
  logic [15:0] pal_mem [PALETTE_DEPTH];
  logic [15:0] mem_rd_r;
  logic        pal_we;
  logic        pal_re;

  assign pal_we = in_fire && (in_data.op == OP_PALETTE) &&
                  ({1'b0, in_data.palette_index} < DEPTH_L);
  assign pal_re = iss_valid && (iss_src == SRC_PAL) && !iss_bad;

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[in_data.palette_index[AW-1:0]] <= in_data.palette_value;
    end
    if (pal_re) begin
      mem_rd_r <= pal_mem[iss_idx[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // read stage: colour word expanded to rgb888 with alpha
  // --------------------------------------------------------------------------
  src_t        s1_src_r;
  logic [23:0] s1_raw_r;
  logic        s1_bad_r;
  logic        s1_last_r;
  logic        s1_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= iss_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_src_r  <= iss_src;
    s1_raw_r  <= iss_raw;
    s1_bad_r  <= iss_bad;
    s1_last_r <= iss_last;
    s1_end_r  <= iss_end;
  end

  // alpha from the high byte of the colour word
  function automatic logic [7:0] alpha_of(input logic [7:0] h);
    if (h == 8'h00) begin
      return 8'h00;
    end else if (!h[7] || (h[6:0] == 7'h00)) begin
      return 8'hff;
    end
    return 8'h7f;
  endfunction

  logic [15:0] s1_word;
  tpd_out_t    s1_res;

  assign s1_word = (s1_src_r == SRC_PAL) ? mem_rd_r : s1_raw_r[15:0];

  always_comb begin
    s1_res.last_of_run  = s1_last_r;
    s1_res.end_of_image = s1_end_r;
    s1_res.bad_index    = 1'b0;
    if (s1_src_r == SRC_RGB) begin
      s1_res.red   = s1_raw_r[23:16];
      s1_res.green = s1_raw_r[15:8];
      s1_res.blue  = s1_raw_r[7:0];
      s1_res.alpha = 8'hff;
    end else if (s1_bad_r) begin
      s1_res.red       = '0;
      s1_res.green     = '0;
      s1_res.blue      = '0;
      s1_res.alpha     = '0;
      s1_res.bad_index = 1'b1;
    end else begin
      // 5-bit channels widened by repeating their top bits
      s1_res.red   = {s1_word[4:0], s1_word[4:2]};
      s1_res.green = {s1_word[9:5], s1_word[9:7]};
      s1_res.blue  = {s1_word[14:10], s1_word[14:12]};
      s1_res.alpha = alpha_of(s1_word[15:8]);
    end
  end

  // --------------------------------------------------------------------------
  // result queue: lets the read stage drain while the consumer stalls
  // --------------------------------------------------------------------------
  tpd_out_t       q_mem_r [QDEPTH];
  logic [QPW-1:0] q_wr_r;
  logic [QPW-1:0] q_rd_r;
  logic           q_push;
  logic           q_pop;

  assign q_push    = s1_valid_r;
  assign out_valid = (q_cnt_r != '0);
  assign q_pop     = out_valid && out_ready;
  assign out_data  = q_mem_r[q_rd_r];

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wr_r] <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wr_r <= (q_wr_r == QPW'(QDEPTH - 1)) ? '0 : QPW'(q_wr_r + 1'b1);
      end
      if (q_pop) begin
        q_rd_r <= (q_rd_r == QPW'(QDEPTH - 1)) ? '0 : QPW'(q_rd_r + 1'b1);
      end
      q_cnt_r <= QCW'(q_cnt_r + QCW'(q_push) - QCW'(q_pop));
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_queue_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && !q_pop && (q_cnt_r == QCW'(QDEPTH))))
    else $error("result queue overflow");

  a_nibble_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.op == OP_DATA) && (mode_r == MODE_PAL4) && !cnt_end)
    |=> nib_pend_r)
    else $error("clut4 high nibble not scheduled");

  a_stage_from_issue : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(iss_valid))
    else $error("read stage valid without an issue");

  a_end_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_image) |-> out_data.last_of_run)
    else $error("end of image on a beat that is not last of run");

  a_bad_is_black : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_index) |->
    ((out_data.red == '0) && (out_data.green == '0) && (out_data.blue == '0) &&
     (out_data.alpha == '0)))
    else $error("bad index beat carries colour");

endmodule

/* tb/sv/tb_tim_pixel_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tim_pixel_decoder_unit
// self-checking bench for the texture pixel decoder: a queue-fed driver
// sends palette writes and image bytes, a local decoder predicts every
// pixel, and a monitor compares each output beat field by field
// ----------------------------------------------------------------------------
module tb_tim_pixel_decoder_unit;
  import tpd_pkg::*;

  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
  localparam int DRAIN_CYCLES = 8;     // pipeline settle time
  localparam int ITEM_TARGET  = 470;   // no new phase past this

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tpd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tpd_out_t out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tim_pixel_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // local decoder state, mirrors what the block should hold
  // --------------------------------------------------------------------------
  pix_mode_t   cur_mode;
  logic [15:0] img_width;
  logic [15:0] img_height;
  logic [8:0]  pal_count;
  logic [15:0] pal_mem [256];
  logic [7:0]  held_first;
  logic [7:0]  held_second;
  logic [1:0]  byte_phase;
  logic [17:0] line_left;
  logic [31:0] pixels_done;

  tpd_out_t pixels_due[$];    // predicted pixels not yet seen on the output
  tpd_in_t  beats_pending[$]; // input beats waiting for the driver
  bit       pal_staged [256]; // entries already queued for writing
  int       items_made;
  int       fails;
  bit       no_idle;          // both sides run flat out while set
  bit       hold_req;         // asks the receiver for its long hold-off
  bit       hold_done;
  int       hold_left;
  int       idle_cycles;

  function automatic tpd_out_t color_pixel(logic [15:0] w, bit last, bit eoi);
    tpd_out_t p;
    logic [7:0] h;
    h = w[15:8];
    // 5-bit channels widened by repeating their top bits
    p.red   = {w[4:0], w[4:2]};
    p.green = {w[9:5], w[9:7]};
    p.blue  = {w[14:10], w[14:12]};
    if (h == 8'h00) p.alpha = 8'h00;
    else if (!h[7]) p.alpha = 8'hff;
    else if (h[6:0] == 7'd0) p.alpha = 8'hff;
    else p.alpha = 8'h7f;
    p.bad_index    = 1'b0;
    p.last_of_run  = last;
    p.end_of_image = eoi;
    return p;
  endfunction

  function automatic tpd_out_t palette_pixel(logic [7:0] idx, bit last, bit eoi);
    tpd_out_t p;
    if ({1'b0, idx} >= pal_count) begin
      p = '0;
      p.bad_index    = 1'b1;
      p.last_of_run  = last;
      p.end_of_image = eoi;
      return p;
    end
    return color_pixel(pal_mem[idx], last, eoi);
  endfunction

  // counts one pixel, reports whether it completes the image
  function automatic bit count_pixel();
    logic [31:0] w, h, total;
    w = (img_width == 0) ? 32'd1 : 32'(img_width);
    h = (img_height == 0) ? 32'd1 : 32'(img_height);
    total = w * h;
    if (pixels_done + 32'd1 >= total) begin
      pixels_done = 0;
      byte_phase  = 0;
      return 1'b1;
    end
    pixels_done = pixels_done + 32'd1;
    return 1'b0;
  endfunction

  function automatic void decode_beat(tpd_in_t beat);
    logic [7:0]  b;
    logic [17:0] w;
    bit          eoi;
    b = beat.data_byte;
    if (beat.op == OP_PALETTE) begin
      pal_mem[beat.palette_index] = beat.palette_value;
      return;
    end
    case (cur_mode)
      MODE_PAL4: begin
        // low nibble first; an image ending here drops the high nibble
        eoi = count_pixel();
        if (eoi) begin
          pixels_due.push_back(palette_pixel({4'd0, b[3:0]}, 1'b1, 1'b1));
          return;
        end
        pixels_due.push_back(palette_pixel({4'd0, b[3:0]}, 1'b0, 1'b0));
        eoi = count_pixel();
        pixels_due.push_back(palette_pixel({4'd0, b[7:4]}, 1'b1, eoi));
      end
      MODE_PAL8: begin
        eoi = count_pixel();
        pixels_due.push_back(palette_pixel(b, 1'b1, eoi));
      end
      MODE_DIRECT15: begin
        if (byte_phase == 0) begin
          held_first = b;
          byte_phase = 1;
          return;
        end
        byte_phase = 0;
        eoi = count_pixel();
        pixels_due.push_back(color_pixel({b, held_first}, 1'b1, eoi));
      end
      default: begin
        // direct 24-bit: odd-width lines carry one pad byte at their end
        w = (img_width == 0) ? 18'd1 : 18'(img_width);
        if (byte_phase == 0) begin
          if (line_left == 0) begin
            line_left = w * 18'd3 + {17'd0, w[0]};
          end else if (line_left < 3) begin
            line_left = 18'(line_left - 18'd1);
            return;
          end
        end
        if (line_left > 0) line_left = 18'(line_left - 18'd1);
        if (byte_phase == 0) begin
          held_first = b;
          byte_phase = 1;
        end else if (byte_phase == 1) begin
          held_second = b;
          byte_phase = 2;
        end else begin
          byte_phase = 0;
          eoi = count_pixel();
          pixels_due.push_back({held_first, held_second, b, 8'hff, 1'b0, 1'b1, eoi});
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [15:0] pick_color();
    case ($urandom_range(3))
      0:       return {8'h00, 8'($urandom_range(255))};
      1:       return {8'h80, 8'($urandom_range(255))};
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(1, 6));
    if (r < 80) return 16'($urandom_range(7, 40));
    if (r < 88) return 16'd0;
    if (r < 94) return 16'd65535;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic void push_pal(logic [7:0] idx, logic [15:0] val);
    tpd_in_t beat;
    beat.op            = OP_PALETTE;
    beat.palette_index = idx;
    beat.palette_value = val;
    beat.data_byte     = 8'($urandom_range(255));  // ignored on a palette write
    pal_staged[idx] = 1'b1;
    beats_pending.push_back(beat);
    items_made++;
  endfunction

  // an in-range index that was never written gets a palette write first
  function automatic void stage_index(logic [7:0] idx);
    if ({1'b0, idx} < pal_count && !pal_staged[idx]) push_pal(idx, pick_color());
  endfunction

  function automatic void push_data(logic [7:0] b);
    tpd_in_t beat;
    if (cur_mode == MODE_PAL4) begin
      stage_index({4'd0, b[3:0]});
      stage_index({4'd0, b[7:4]});
    end else if (cur_mode == MODE_PAL8) begin
      stage_index(b);
    end
    beat.op            = OP_DATA;
    beat.palette_index = 8'($urandom_range(255));
    beat.palette_value = 16'($urandom_range(65535));
    beat.data_byte     = b;
    beats_pending.push_back(beat);
    items_made++;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PALETTE_COUNT: pal_count = val[8:0];
      default: begin
        if (idx == CFG_PIXEL_MODE) cur_mode = pix_mode_t'(val[1:0]);
        else if (idx == CFG_WIDTH_PIXELS) img_width = val;
        else img_height = val;
        // geometry and mode writes restart the image
        byte_phase  = 0;
        line_left   = 0;
        pixels_done = 0;
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_image(input pix_mode_t m, input logic [15:0] w,
                             input logic [15:0] h, input logic [8:0] cnt);
    cfg_write(CFG_PIXEL_MODE, CFG_DATA_W'(m));
    cfg_write(CFG_WIDTH_PIXELS, w);
    cfg_write(CFG_HEIGHT_ROWS, h);
    cfg_write(CFG_PALETTE_COUNT, CFG_DATA_W'(cnt));
  endtask

  // wait for every queued beat and predicted pixel, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (beats_pending.size() != 0 || in_valid || pixels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // driver: offers queued beats, predicts each one as it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_beat(in_data);
      // slot is free once nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (beats_pending.size() != 0 && (no_idle || $urandom_range(99) >= 34)) begin
          in_data  <= beats_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 34);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every output beat against the oldest predicted pixel
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    tpd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        $error("pixel %h with none expected", out_data);
        fails++;
      end else begin
        want = pixels_due.pop_front();
        check_field("red", want.red, out_data.red);
        check_field("green", want.green, out_data.green);
        check_field("blue", want.blue, out_data.blue);
        check_field("alpha", want.alpha, out_data.alpha);
        check_field("bad_index", 8'(want.bad_index), 8'(out_data.bad_index));
        check_field("last_of_run", 8'(want.last_of_run), 8'(out_data.last_of_run));
        check_field("end_of_image", 8'(want.end_of_image), 8'(out_data.end_of_image));
      end
    end
  end

  // watchdog: too long without a beat on either side means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int k, n, r;
    pix_mode_t   m;
    logic [15:0] w, h;
    logic [8:0]  cnt;

    // reset values of the decoder
    cur_mode    = MODE_DIRECT15;
    img_width   = 16'd1;
    img_height  = 16'd1;
    pal_count   = 9'd0;
    held_first  = '0;
    held_second = '0;
    byte_phase  = '0;
    line_left   = '0;
    pixels_done = '0;
    items_made  = 0;
    fails       = 0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    hold_left   = 0;
    idle_cycles = 0;
    foreach (pal_staged[i]) pal_staged[i] = 1'b0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: direct 15-bit one-pixel images, every alpha case
    push_data(8'h00); push_data(8'h00);  // fully transparent black
    push_data(8'hff); push_data(8'hff);  // semi transparent white
    push_data(8'h1f); push_data(8'h80);  // high byte exactly 0x80, red only
    push_data(8'he0); push_data(8'h03);  // green only
    push_data(8'h00); push_data(8'h7c);  // blue only
    drain();

    // clut4, 3 pixel image: second byte ends on its low nibble
    setup_image(MODE_PAL4, 16'd3, 16'd1, 9'd4);
    push_pal(8'd0, 16'h0000);
    push_pal(8'd1, 16'hffff);
    push_pal(8'd2, 16'h8000);
    push_pal(8'd3, 16'h7fff);
    push_data(8'h10);
    push_data(8'hf2);  // index 15 is past the loaded count, but the image ends first
    push_data(8'h31);  // starts the next image
    drain();

    // direct 24-bit, odd width: pad byte after each line, the last one too
    setup_image(MODE_DIRECT24, 16'd1, 16'd2, 9'd0);
    push_data(8'h01); push_data(8'h02); push_data(8'h03); push_data(8'haa);
    push_data(8'h04); push_data(8'h05); push_data(8'h06); push_data(8'hbb);
    drain();

    // random phases, each under a fresh setting
    k = 0;
    while (items_made < ITEM_TARGET) begin
      m = pix_mode_t'($urandom_range(3));
      w = pick_dim();
      h = pick_dim();
      r = $urandom_range(99);
      cnt = (r < 20) ? 9'd0 : (r < 40) ? 9'd256 : 9'($urandom_range(256));
      if (k == 1) m = MODE_PAL4;  // dense output for the hold-off phase
      if (k == 2) begin
        m = MODE_PAL8; w = 16'd65535; h = 16'd65535; cnt = 9'd256;
      end
      if (k == 3) begin
        m = MODE_DIRECT24; w = 16'd0; h = 16'd0; cnt = 9'd0;
      end
      setup_image(m, w, h, cnt);
      hold_req = (k == 1);
      no_idle  = (k == 4);
      n = (k == 1) ? 100 : $urandom_range(30, 70);
      repeat (n) begin
        if ($urandom_range(99) < 8) push_pal(8'($urandom_range(255)), pick_color());
        else push_data(8'($urandom_range(255)));
      end
      drain();
      no_idle = 1'b0;
      k++;
    end

    repeat (20) @(posedge clk);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/tpd_pkg.sv
rtl/tim_pixel_decoder_unit.sv
tb/sv/tb_tim_pixel_decoder_unit.sv
